@@ src/rpb_pkg.sv @@
// Package for the RGB565 pixel blender: beat types, stage records,
// register and mode codes, and the constant dividers used by multiply mode.
// No dependencies.
package rpb_pkg;

    // Register index codes, word addressed on the config port
    localparam logic [1:0] REG_BLEND_MODE   = 2'd0;
    localparam logic [1:0] REG_ALPHA_ENABLE = 2'd1;
    localparam logic [1:0] REG_MASK_ENABLE  = 2'd2;
    localparam logic [1:0] REG_MASK_COLOR   = 2'd3;

    // Blend mode codes; any other code blends as multiply
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_ADDITIVE = 2'd1;

    // Alpha levels with special handling
    localparam logic [7:0] ALPHA_ZERO   = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Channel maxima
    localparam logic [5:0] MAX_5BIT = 6'h1F;
    localparam logic [5:0] MAX_6BIT = 6'h3F;

    typedef struct packed {
        logic [23:0] src_color;
        logic [15:0] bg_color;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] out_color;
        logic        write_enable;
    } t_out_beat;

    // What a beat turns into once the key and alpha tests are done
    typedef enum logic [1:0] {
        K_SKIP,
        K_PASS,
        K_BLEND
    } t_kind;

    // Products stage: channel 0 red, 1 green, 2 blue
    typedef struct packed {
        t_kind            kind;
        logic [15:0]      pass_color;
        logic [7:0]       alpha;
        logic [2:0][13:0] sa;
        logic [2:0][13:0] dn;
        logic [2:0][11:0] sd;
        logic [2:0][5:0]  d;
    } t_stg_b;

    // Quotient stage: normal and additive results are final here
    typedef struct packed {
        t_kind            kind;
        logic [15:0]      pass_color;
        logic [7:0]       alpha;
        logic [2:0][5:0]  q;
        logic [2:0][13:0] dn;
        logic [2:0][5:0]  nrm;
        logic [2:0][5:0]  add;
    } t_stg_c;

    // Floor of x / 31 for x up to 961: reciprocal estimate, one correction
    function automatic logic [5:0] div31(input logic [10:0] x);
        logic [16:0] t;
        logic [5:0]  q0;
        logic [11:0] prod;
        logic [11:0] rem;
        t    = ({6'b0, x} << 5) + {6'b0, x};
        q0   = t[15:10];
        prod = 12'(q0) * 12'd31;
        rem  = {1'b0, x} - prod;
        return (rem >= 12'd31) ? q0 + 6'd1 : q0;
    endfunction

    // Floor of x / 63 for x up to 3969: reciprocal estimate, one correction
    function automatic logic [5:0] div63(input logic [11:0] x);
        logic [17:0] t;
        logic [5:0]  q0;
        logic [11:0] prod;
        logic [11:0] rem;
        t    = ({6'b0, x} << 6) + {6'b0, x};
        q0   = t[17:12];
        prod = 12'(q0) * 12'd63;
        rem  = x - prod;
        return (rem >= 12'd63) ? q0 + 6'd1 : q0;
    endfunction

endpackage

@@ src/rgb565_pixel_blender.sv @@
// RGB565 pixel blender top level: config registers and a four-register
// pipeline for colour key, alpha and blend. Depends on rpb_pkg.
//
//  channel   signals                          width  role
//  in        i_in_valid/i_in_data/o_in_stall  40     source + background pixel
//  out       o_out_valid/o_out_data/i_out_stall 17   pixel + write enable
//  config    psel/penable/pwrite/paddr/...    32     four registers at 4*i
//
// One beat per clock sustained while the output is not stalled. A result
// passes the input register, products, quotients and the result register;
// the split follows the multiply mode chain (product, divide by channel
// maximum, product). Reset clears the valid bits and the config registers.
// Each stage holds while the one after it is full and stalled, so a stall on
// the output reaches the input only once every stage holds a beat.
module rgb565_pixel_blender (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  rpb_pkg::t_in_beat i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output rpb_pkg::t_out_beat o_out_data,
    input  logic              i_out_stall,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rpb_pkg::*;

    logic [1:0]  r_blend_mode;
    logic        r_alpha_enable;
    logic        r_mask_enable;
    logic [23:0] r_mask_color;
    logic        cfg_wr;

    logic        r_a_vld, r_b_vld, r_c_vld, r_out_vld;
    t_in_beat    r_a;
    t_stg_b      r_b, n_b;
    t_stg_c      r_c, n_c;
    t_out_beat   r_out, n_out;
    logic        en_a, en_b, en_c, en_out;

    // Config port: always ready, written on the access cycle
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode   <= MODE_NORMAL;
            r_alpha_enable <= 1'b0;
            r_mask_enable  <= 1'b0;
            r_mask_color   <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BLEND_MODE:   r_blend_mode   <= pwdata[1:0];
                REG_ALPHA_ENABLE: r_alpha_enable <= pwdata[0];
                REG_MASK_ENABLE:  r_mask_enable  <= pwdata[0];
                REG_MASK_COLOR:   r_mask_color   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BLEND_MODE:   prdata = {30'b0, r_blend_mode};
            REG_ALPHA_ENABLE: prdata = {31'b0, r_alpha_enable};
            REG_MASK_ENABLE:  prdata = {31'b0, r_mask_enable};
            REG_MASK_COLOR:   prdata = {8'b0, r_mask_color};
            default:          prdata = '0;
        endcase
    end

    // Stage enables: a stage advances when empty or when the next one advances
    assign en_out     = !r_out_vld || !i_out_stall;
    assign en_c       = !r_c_vld || en_out;
    assign en_b       = !r_b_vld || en_c;
    assign en_a       = !r_a_vld || en_b;
    assign o_in_stall = !en_a;

    // Key and alpha tests, per-channel products
    always_comb begin
        logic [15:0] rgb;
        logic [7:0]  alpha;
        logic [7:0]  inv;
        logic [5:0]  s [3];
        logic [5:0]  d [3];
        rgb   = r_a.src_color[23:8];
        alpha = r_a.src_color[7:0];
        inv   = ALPHA_OPAQUE - alpha;
        s[0]  = {1'b0, rgb[15:11]};
        s[1]  = rgb[10:5];
        s[2]  = {1'b0, rgb[4:0]};
        d[0]  = {1'b0, r_a.bg_color[15:11]};
        d[1]  = r_a.bg_color[10:5];
        d[2]  = {1'b0, r_a.bg_color[4:0]};

        n_b.alpha = alpha;
        if (r_mask_enable && (r_a.src_color == r_mask_color)) begin
            n_b.kind       = K_SKIP;
            n_b.pass_color = '0;
        end else if (r_alpha_enable) begin
            n_b.pass_color = rgb;
            if (alpha == ALPHA_ZERO) begin
                n_b.kind = K_SKIP;
            end else if (alpha == ALPHA_OPAQUE) begin
                n_b.kind = K_PASS;
            end else begin
                n_b.kind = K_BLEND;
            end
        end else begin
            n_b.kind       = K_PASS;
            n_b.pass_color = r_a.src_color[15:0];
        end

        for (int c = 0; c < 3; c++) begin
            n_b.sa[c] = 14'(s[c]) * 14'(alpha);
            n_b.dn[c] = 14'(d[c]) * 14'(inv);
            n_b.sd[c] = 12'(s[c]) * 12'(d[c]);
            n_b.d[c]  = d[c];
        end
    end

    // Quotients for multiply, final normal and additive values
    always_comb begin
        logic [14:0] sum;
        logic [6:0]  acc;
        logic [5:0]  maxv;
        n_c.kind       = r_b.kind;
        n_c.pass_color = r_b.pass_color;
        n_c.alpha      = r_b.alpha;
        for (int c = 0; c < 3; c++) begin
            maxv = (c == 1) ? MAX_6BIT : MAX_5BIT;
            n_c.q[c]   = (c == 1) ? div63(r_b.sd[c]) : div31(r_b.sd[c][10:0]);
            n_c.dn[c]  = r_b.dn[c];
            sum        = 15'(r_b.sa[c]) + 15'(r_b.dn[c]);
            n_c.nrm[c] = sum[13:8] & maxv;
            acc        = 7'(r_b.sa[c][13:8]) + 7'(r_b.d[c]);
            n_c.add[c] = (acc > 7'(maxv)) ? maxv : acc[5:0];
        end
    end

    // Multiply mix, mode select, packing
    always_comb begin
        logic [14:0] sum;
        logic [5:0]  ch [3];
        logic [5:0]  maxv;
        for (int c = 0; c < 3; c++) begin
            maxv = (c == 1) ? MAX_6BIT : MAX_5BIT;
            sum  = 15'(15'(r_c.q[c]) * 15'(r_c.alpha)) + 15'(r_c.dn[c]);
            case (r_blend_mode)
                MODE_NORMAL:   ch[c] = r_c.nrm[c];
                MODE_ADDITIVE: ch[c] = r_c.add[c];
                default:       ch[c] = sum[13:8] & maxv;
            endcase
        end
        case (r_c.kind)
            K_PASS: begin
                n_out.out_color    = r_c.pass_color;
                n_out.write_enable = 1'b1;
            end
            K_BLEND: begin
                n_out.out_color    = {ch[0][4:0], ch[1], ch[2][4:0]};
                n_out.write_enable = 1'b1;
            end
            default: begin
                n_out.out_color    = '0;
                n_out.write_enable = 1'b0;
            end
        endcase
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (en_a)   r_a_vld   <= i_in_valid;
            if (en_b)   r_b_vld   <= r_a_vld;
            if (en_c)   r_c_vld   <= r_b_vld;
            if (en_out) r_out_vld <= r_c_vld;
        end
    end

    // Load payloads only when a beat moves in
    always_ff @(posedge i_clk) begin
        if (en_a && i_in_valid) r_a   <= i_in_data;
        if (en_b && r_a_vld)    r_b   <= n_b;
        if (en_c && r_b_vld)    r_c   <= n_c;
        if (en_out && r_c_vld)  r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ src/rpb_checker.sv @@
// Port-level checker for the RGB565 pixel blender, bound to the top level.
// Depends on rpb_pkg and rgb565_pixel_blender.
module rpb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input rpb_pkg::t_out_beat o_out_data,
    input logic               i_out_stall
);
    import rpb_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    // Drop all beats on reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Back pressure reaches the input only from a stalled full output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back pressure");

    // Skipped pixels carry a zero colour
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.write_enable |-> o_out_data.out_color == 16'h0000)
        else $error("skipped pixel with nonzero colour");

endmodule

bind rgb565_pixel_blender rpb_checker u_rpb_checker (.*);
